FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked once reset has been released
`define PFVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define PFVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pfvd_pkg.sv
package pfvd_pkg;

  typedef enum logic [2:0] {
    VT_INT32  = 3'd0,
    VT_UINT32 = 3'd1,
    VT_INT64  = 3'd2,
    VT_UINT64 = 3'd3,
    VT_BOOL   = 3'd4,
    VT_FLOAT  = 3'd5,
    VT_DOUBLE = 3'd6,
    VT_STRING = 3'd7
  } vtype_t;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_TRUNCATED = 3'd1,
    ERR_OVERLONG  = 3'd2,
    ERR_BAD_LEN   = 3'd3,
    ERR_OVERRUN   = 3'd4
  } err_t;

  localparam logic CFG_VALUE_TYPE  = 1'b0;
  localparam logic CFG_PACKED_MODE = 1'b1;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 3;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [3:0] VarintLastIdx = 4'd9;
  localparam logic [7:0] ContMask      = 8'h80;
  localparam logic [7:0] PayloadMask   = 8'h7f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  typedef struct packed {
    logic [63:0] value;
    logic        element_end;
    logic        field_end;
    logic        empty_field;
    logic [2:0]  error_code;
  } out_t;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] payload;
    logic       cont;
    logic       eos;
  } q_t;

  typedef struct packed {
    vtype_t value_type;
    logic   packed_mode;
  } cfg_t;

endpackage

FILE: src/pfvd_front.sv
module pfvd_front (
  input  logic           in_valid,
  input  pfvd_pkg::in_t  in_data,
  input  logic           q_full,
  output logic           in_stall,
  output logic           push,
  output pfvd_pkg::q_t   push_data
);
  import pfvd_pkg::*;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_data.data    = in_data.data_byte;
    push_data.payload = 7'(in_data.data_byte & PayloadMask);
    push_data.cont    = (in_data.data_byte & ContMask) != 8'd0;
    push_data.eos     = in_data.end_of_stream;
  end

endmodule

FILE: src/pfvd_queue.sv
module pfvd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pfvd_pkg::q_t  push_data,
  input  logic          pop,
  output pfvd_pkg::q_t  head,
  output logic          head_valid,
  output logic          full
);
  import pfvd_pkg::*;

  q_t               mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;

  assign head       = mem[rd_ptr];
  assign head_valid = count != '0;
  assign full       = count == (QPtrW+1)'(QDepth);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/pfvd_back.sv
module pfvd_back (
  input  logic            clk,
  input  logic            rst,
  input  pfvd_pkg::cfg_t  cfg,
  input  pfvd_pkg::q_t    head,
  input  logic            head_valid,
  output logic            pop,
  output logic            out_valid,
  output pfvd_pkg::out_t  out_data,
  input  logic            out_stall
);
  import pfvd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VAR_SINGLE,
    PH_VAR_PACKED,
    PH_FIX_SINGLE,
    PH_FIX_PACKED,
    PH_LENGTH,
    PH_STRING
  } phase_t;

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  vidx, vidx_next;
  logic [2:0]  fidx, fidx_next;
  logic [30:0] rem, rem_next;
  out_t        res;
  logic        res_valid;

  function automatic logic [3:0] elem_bytes(vtype_t vt);
    logic [3:0] n;
    n = 4'd1;
    case (vt)
      VT_INT32, VT_UINT32, VT_FLOAT:  n = 4'd4;
      VT_INT64, VT_UINT64, VT_DOUBLE: n = 4'd8;
      default:                        n = 4'd1;
    endcase
    return n;
  endfunction

  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    phase_t      ph;
    logic [3:0]  n;
    logic [6:0]  vsh;
    logic [63:0] vterm;
    logic [63:0] fed;
    logic [63:0] fix_acc;
    logic [63:0] ival;
    logic        over;
    logic [30:0] rem_d;
    logic [31:0] len32;
    logic        is_int;

    phase_next = phase;
    acc_next   = acc;
    vidx_next  = vidx;
    fidx_next  = fidx;
    rem_next   = rem;
    res        = '0;
    res_valid  = 1'b0;

    n      = elem_bytes(cfg.value_type);
    is_int = cfg.value_type == VT_INT32 || cfg.value_type == VT_UINT32 ||
             cfg.value_type == VT_INT64 || cfg.value_type == VT_UINT64;
    vsh    = {3'b000, vidx} * 7'd7;
    vterm  = (vidx < VarintLastIdx) ? ({57'd0, head.payload} << vsh)
                                    : {head.data[0], 63'd0};
    fed     = acc | vterm;
    over    = head.cont && (vidx >= VarintLastIdx);
    fix_acc = acc | ({56'd0, head.data} << {fidx, 3'b000});
    rem_d   = (rem != '0) ? rem - 1'b1 : rem;
    len32   = fed[31:0];
    ival    = (cfg.value_type == VT_INT32 || cfg.value_type == VT_UINT32)
              ? {32'd0, fed[31:0]} : fed;

    ph = phase;
    if (phase == PH_IDLE) begin
      if (cfg.value_type == VT_STRING || cfg.packed_mode) begin
        ph = PH_LENGTH;
      end else if (is_int) begin
        ph = PH_VAR_SINGLE;
      end else begin
        ph = PH_FIX_SINGLE;
      end
    end

    if (head.eos) begin
      if (phase != PH_IDLE) begin
        res_valid       = 1'b1;
        res.field_end   = 1'b1;
        res.error_code  = ERR_TRUNCATED;
      end
    end else begin
      phase_next = ph;
      unique case (ph)
        PH_LENGTH: begin
          if (over) begin
            res_valid      = 1'b1;
            res.field_end  = 1'b1;
            res.error_code = ERR_OVERLONG;
          end else if (head.cont) begin
            acc_next  = fed;
            vidx_next = vidx + 1'b1;
          end else begin
            acc_next  = '0;
            vidx_next = '0;
            fidx_next = '0;
            rem_next  = len32[30:0];
            if (len32[31]) begin
              res_valid      = 1'b1;
              res.field_end  = 1'b1;
              res.error_code = ERR_BAD_LEN;
            end else if (cfg.value_type == VT_STRING || is_int) begin
              if (len32 == 32'd0) begin
                res_valid       = 1'b1;
                res.field_end   = 1'b1;
                res.empty_field = 1'b1;
              end else begin
                phase_next = (cfg.value_type == VT_STRING) ? PH_STRING : PH_VAR_PACKED;
              end
            end else if (len32 == 32'd0 || (len32[3:0] & (n - 1'b1)) != 4'd0) begin
              res_valid      = 1'b1;
              res.field_end  = 1'b1;
              res.error_code = ERR_BAD_LEN;
            end else begin
              phase_next = PH_FIX_PACKED;
            end
          end
        end
        PH_VAR_SINGLE: begin
          if (over) begin
            res_valid      = 1'b1;
            res.field_end  = 1'b1;
            res.error_code = ERR_OVERLONG;
          end else if (head.cont) begin
            acc_next  = fed;
            vidx_next = vidx + 1'b1;
          end else begin
            res_valid       = 1'b1;
            res.value       = ival;
            res.element_end = 1'b1;
            res.field_end   = 1'b1;
          end
        end
        PH_VAR_PACKED: begin
          rem_next = rem_d;
          if (over) begin
            res_valid      = 1'b1;
            res.field_end  = 1'b1;
            res.error_code = ERR_OVERLONG;
          end else if (head.cont) begin
            if (rem_d == '0) begin
              res_valid      = 1'b1;
              res.field_end  = 1'b1;
              res.error_code = ERR_OVERRUN;
            end else begin
              acc_next  = fed;
              vidx_next = vidx + 1'b1;
            end
          end else begin
            res_valid       = 1'b1;
            res.value       = ival;
            res.element_end = 1'b1;
            res.field_end   = rem_d == '0;
            acc_next        = '0;
            vidx_next       = '0;
            fidx_next       = '0;
          end
        end
        PH_FIX_SINGLE, PH_FIX_PACKED: begin
          if (ph == PH_FIX_PACKED) begin
            rem_next = rem_d;
          end
          if ({1'b0, fidx} + 4'd1 >= n) begin
            res_valid       = 1'b1;
            res.value       = fix_acc;
            res.element_end = 1'b1;
            res.field_end   = (ph == PH_FIX_SINGLE) || (rem_d == '0);
            acc_next        = '0;
            vidx_next       = '0;
            fidx_next       = '0;
          end else begin
            acc_next  = fix_acc;
            fidx_next = fidx + 1'b1;
          end
        end
        PH_STRING: begin
          rem_next        = rem_d;
          res_valid       = 1'b1;
          res.value       = {56'd0, head.data};
          res.element_end = rem_d == '0;
          res.field_end   = rem_d == '0;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    if (res_valid && res.field_end) begin
      phase_next = PH_IDLE;
      acc_next   = '0;
      vidx_next  = '0;
      fidx_next  = '0;
      rem_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      acc       <= '0;
      vidx      <= '0;
      fidx      <= '0;
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        acc   <= acc_next;
        vidx  <= vidx_next;
        fidx  <= fidx_next;
        rem   <= rem_next;
      end
      if (!out_valid || !out_stall) begin
        out_valid <= pop && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_data <= res;
    end
  end

endmodule

FILE: src/protobuf_field_value_decoder.sv
// Decodes the payload bytes of one protobuf field, one byte per request, into
// elements of the configured value type (varint integers, fixed-width bool,
// float and double, packed repeated runs, or string bytes passed through).
// Throughput is one byte per clock when the result side does not stall: each
// byte costs one update of the decoder's accumulator and length counter, and
// a two-entry queue between input and decoder lets each side stall on its own.
// A byte that yields a result is first stored in the queue, then its result is registered at the output.
// The user must write value_type and packed_mode only between fields; the block does not enforce it.
`include "assert_macros.svh"

module protobuf_field_value_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pfvd_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pfvd_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfvd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [pfvd_pkg::CfgDataW-1:0]       cfg_data
);
  import pfvd_pkg::*;

  cfg_t cfg;
  logic push;
  q_t   push_data;
  logic pop;
  q_t   head;
  logic head_valid;
  logic q_full;
  logic err_shape_ok;
  logic empty_shape_ok;
  logic err_known;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_type  <= VT_INT32;
      cfg.packed_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VALUE_TYPE:  cfg.value_type  <= vtype_t'(cfg_data);
        CFG_PACKED_MODE: cfg.packed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pfvd_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_data (push_data)
  );

  pfvd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  pfvd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

  assign err_shape_ok   = out_data.field_end && !out_data.element_end &&
                          out_data.value == 64'd0 && !out_data.empty_field;
  assign empty_shape_ok = out_data.field_end && !out_data.element_end &&
                          out_data.error_code == ERR_OK;
  assign err_known      = out_data.error_code == ERR_OK ||
                          out_data.error_code == ERR_TRUNCATED ||
                          out_data.error_code == ERR_OVERLONG ||
                          out_data.error_code == ERR_BAD_LEN ||
                          out_data.error_code == ERR_OVERRUN;

  `PFVD_ASSERT(a_err_shape, out_valid && out_data.error_code != ERR_OK |-> err_shape_ok, "error result malformed")
  `PFVD_ASSERT(a_empty_shape, out_valid && out_data.empty_field |-> empty_shape_ok, "empty result malformed")
  `PFVD_ASSERT(a_err_range, out_valid |-> err_known, "unknown error code")
  `PFVD_ASSERT_ALWAYS(a_pop_needs_item, pop |-> head_valid && !rst, "decoder took from empty queue")

endmodule
